// ===== hw/rtl/abe_pkg.sv =====
// abe_pkg: shared types and constants for the allocation bitmap engine
// no dependencies; used by abe_word_unit and allocation_bitmap_engine_unit

package abe_pkg;

  // fixed field widths of the request and result ports
  localparam int POS_W  = 13;   // positions, counts, sizes, run lengths
  localparam int IDX_W  = 12;   // position field
  localparam int FUNC_W = 2;

  // bit offset inside one word, wide enough to hold a 64-bit word's width
  localparam int OFS_W = 7;

  // default geometry
  localparam int DEF_WORD_BITS     = 32;
  localparam int DEF_CAPACITY_BITS = 4096;

  // size register value after reset
  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(4096);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE_BIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_RANGE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT_ZEROS = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_COUNT_ONES  = 2'd3;

  // per-word control handed to the word unit
  typedef struct packed {
    logic             count_op;   // 1: measure run, 0: write mask
    logic             value;      // fill value or the value being counted
    logic [OFS_W-1:0] first_ofs;  // first covered bit, msb-first
    logic [OFS_W-1:0] last_ofs;   // last covered bit, msb-first
  } word_ctl_t;

  // per-word run measurement
  typedef struct packed {
    logic [OFS_W-1:0] run;        // matching bits inside the covered span
    logic             hit;        // a differing bit ended the run here
  } word_res_t;

endpackage

// ===== hw/rtl/abe_word_unit.sv =====
// abe_word_unit: shared per-word unit, masked write and leading-run count
// depends on abe_pkg

module abe_word_unit #(
  parameter int WORD_BITS = abe_pkg::DEF_WORD_BITS
) (
  input  abe_pkg::word_ctl_t     ctl,
  input  logic [WORD_BITS-1:0]   rd_word,
  output logic [WORD_BITS-1:0]   wr_word,
  output abe_pkg::word_res_t     res
);
  import abe_pkg::*;

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] diff;
  logic [WORD_BITS-1:0] aligned;
  logic [OFS_W-1:0]     end_shift;
  logic [OFS_W-1:0]     span;
  logic [OFS_W-1:0]     lead;

  assign ones      = '1;
  assign end_shift = OFS_W'(ctl.last_ofs + 1'b1);

  // bit 0 of the span sits at the word's msb
  assign mask    = (ones >> ctl.first_ofs) & ~(ones >> end_shift);
  assign wr_word = ctl.value ? (rd_word | mask) : (rd_word & ~mask);

  // a one in diff marks a bit that breaks the run
  assign diff    = ctl.value ? ~rd_word : rd_word;
  assign aligned = diff << ctl.first_ofs;
  assign span    = OFS_W'(ctl.last_ofs - ctl.first_ofs + 1'b1);

  // leading zero count of the aligned word
  always_comb begin
    lead = OFS_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (aligned[WORD_BITS-1-i]) begin
        lead = OFS_W'(i);
      end
    end
  end

  always_comb begin
    res.hit = (lead < span) && ctl.count_op;
    res.run = (lead < span) ? lead : span;
  end

endmodule

// ===== hw/rtl/allocation_bitmap_engine_unit.sv =====
// allocation_bitmap_engine_unit: top level of the allocation bitmap engine
// depends on abe_pkg and abe_word_unit

// The bitmap lives in a single-port-write, registered-read word memory of
// CAPACITY_BITS / WORD_BITS words; bit p is bit (p mod WORD_BITS) of word
// p / WORD_BITS counted from the msb. After reset the engine runs a clearing
// pass of one word per cycle and holds busy high until it is done; size
// writes are taken throughout. An item is taken when start is high and busy
// is low. A refused item (out of range, or an empty range write) answers on
// the next cycle. A performed item walks the words it touches through one
// shared word unit, one word per cycle: each word is read into the registered
// read data ahead of the modify/measure stage. A count stops at the word
// holding the first differing bit or the last bit in size. The result appears
// on done, accepted and run_length; done is high for exactly one cycle, while
// accepted and run_length hold until the next item is taken. The receiver
// cannot stall it, and a new item may be started in the done cycle.
module allocation_bitmap_engine_unit #(
  parameter int WORD_BITS     = abe_pkg::DEF_WORD_BITS,
  parameter int CAPACITY_BITS = abe_pkg::DEF_CAPACITY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // size register
  input  logic                        cfg_write,
  input  logic [abe_pkg::POS_W-1:0]   cfg_data,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic [abe_pkg::FUNC_W-1:0]  func,
  input  logic [abe_pkg::IDX_W-1:0]   position,
  input  logic [abe_pkg::POS_W-1:0]   run_count,
  input  logic                        fill_value,
  input  logic [abe_pkg::POS_W-1:0]   limit,
  // result
  output logic                        done,
  output logic                        accepted,
  output logic [abe_pkg::POS_W-1:0]   run_length
);
  import abe_pkg::*;

  localparam int WORD_COUNT = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  // largest size the 13-bit register can reach inside the capacity
  localparam int SIZE_CLIP  = (CAPACITY_BITS > 8191) ? 8191 : CAPACITY_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WALK  = 3'b100
  } state_t;

  state_t state;

  // configuration
  logic [POS_W-1:0] size_bits;

  // word memory
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 mem_re;

  // clearing pass
  logic [AW-1:0] clr_addr;

  // item context, latched when an item is taken
  logic             count_op;
  logic             value;
  logic [AW-1:0]    last_word;
  logic [OFS_W-1:0] first_ofs;
  logic [OFS_W-1:0] last_ofs;
  logic [POS_W-1:0] lim_eff;
  logic [POS_W-1:0] run_acc;

  // read issue stage
  logic          rd_more;
  logic          rd_first;
  logic [AW-1:0] rd_addr;

  // modify / measure stage
  logic          pv;
  logic          p_first;
  logic          p_last;
  logic [AW-1:0] p_addr;

  // request decode
  logic             take;
  logic [POS_W-1:0] eff_size;
  logic [POS_W-1:0] pos_ext;
  logic [POS_W-1:0] wr_len;
  logic [POS_W-1:0] end_pos;
  logic             is_count;
  logic             in_range;

  // shared word unit
  word_ctl_t            wctl;
  word_res_t            wres;
  logic [WORD_BITS-1:0] wr_word;
  logic [POS_W-1:0]     acc_next;
  logic                 finish;

  assign busy = (state != ST_IDLE);
  assign take = start && !busy;

  // effective size never exceeds the capacity
  assign eff_size = (size_bits > POS_W'(SIZE_CLIP)) ? POS_W'(SIZE_CLIP) : size_bits;
  assign pos_ext  = POS_W'(position);
  assign is_count = (func == FUNC_COUNT_ZEROS) || (func == FUNC_COUNT_ONES);
  // a single-bit write is a range write of length one
  assign wr_len   = (func == FUNC_WRITE_BIT) ? POS_W'(1) : run_count;

  always_comb begin
    if (is_count) begin
      in_range = (pos_ext < eff_size);
      end_pos  = POS_W'(eff_size - 1'b1);
    end else begin
      in_range = (wr_len != '0) && (POS_W'(pos_ext + wr_len) <= eff_size)
                 && !(pos_ext + wr_len < pos_ext);
      end_pos  = POS_W'(pos_ext + wr_len - 1'b1);
    end
  end

  // word unit control for the word in the modify / measure stage
  always_comb begin
    wctl.count_op  = count_op;
    wctl.value     = value;
    wctl.first_ofs = p_first ? first_ofs : '0;
    wctl.last_ofs  = p_last ? last_ofs : OFS_W'(WORD_BITS - 1);
  end

  abe_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word (
    .ctl     (wctl),
    .rd_word (rd_data),
    .wr_word (wr_word),
    .res     (wres)
  );

  assign acc_next = POS_W'(run_acc + POS_W'(wres.run));
  // a write ends at its last word; a count also ends at a differing bit
  assign finish   = pv && (p_last || wres.hit);

  // memory write port: clearing pass or modified word
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if ((state == ST_WALK) && pv && !count_op) begin
      mem_we = 1'b1;
      mem_wa = p_addr;
      mem_wd = wr_word;
    end
  end

  assign mem_re = (state == ST_WALK) && rd_more && !finish;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits <= SIZE_RESET;
    end else if (cfg_write) begin
      size_bits <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_more  <= 1'b0;
      pv       <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(WORD_COUNT - 1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= AW'(clr_addr + 1'b1);
        end
        ST_IDLE: begin
          if (take) begin
            if (in_range) begin
              state   <= ST_WALK;
              rd_more <= 1'b1;
              pv      <= 1'b0;
            end else begin
              // refused: answer at once, nothing touched
              done <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (finish) begin
            state   <= ST_IDLE;
            rd_more <= 1'b0;
            pv      <= 1'b0;
            done    <= 1'b1;
          end else begin
            pv <= mem_re;
            if (mem_re && (rd_addr == last_word)) begin
              rd_more <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item context and pipeline payload
  always_ff @(posedge clk) begin
    if (take) begin
      count_op   <= is_count;
      value      <= is_count ? (func == FUNC_COUNT_ONES) : fill_value;
      rd_addr    <= AW'(POS_W'(pos_ext / WORD_BITS));
      first_ofs  <= OFS_W'(pos_ext % WORD_BITS);
      last_word  <= AW'(POS_W'(end_pos / WORD_BITS));
      last_ofs   <= OFS_W'(end_pos % WORD_BITS);
      lim_eff    <= (limit == '0) ? eff_size : limit;
      run_acc    <= '0;
      rd_first   <= 1'b1;
      accepted   <= 1'b0;
      run_length <= '0;
    end else if (state == ST_WALK) begin
      if (mem_re) begin
        p_addr   <= rd_addr;
        p_first  <= rd_first;
        p_last   <= (rd_addr == last_word);
        rd_first <= 1'b0;
        rd_addr  <= AW'(rd_addr + 1'b1);
      end
      if (pv && count_op) begin
        run_acc <= acc_next;
      end
      if (finish) begin
        accepted   <= 1'b1;
        run_length <= !count_op ? '0 : ((acc_next > lim_eff) ? lim_eff : acc_next);
      end
    end
  end

  // no result while the clearing pass runs
  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !done)
    else $error("result during clearing pass");

  // a refused item never reports a run
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> (run_length == '0))
    else $error("refused item with nonzero run");

  // a reported run never exceeds the latched cap
  a_run_capped: assert property (@(posedge clk) disable iff (rst)
    (done && accepted && count_op) |-> (run_length <= lim_eff))
    else $error("run above cap");

  // the modify stage only holds a word during a walk
  a_stage_in_walk: assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == ST_WALK))
    else $error("stage valid outside walk");

  // memory writes come from the clearing pass or a range write only
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == ST_WALK)) |-> (!count_op && pv))
    else $error("memory write during a count");

endmodule
